// ===== src/p2c_pkg.sv =====
// Package for the planar-to-chunky image converter.
// Holds the size limits, derived widths and result kind codes.
// No dependencies.
package p2c_pkg;

  // Image size limits.
  localparam int unsigned MaxWidth    = 640;
  localparam int unsigned MaxHeight   = 400;
  localparam int unsigned RowBytesMax = (MaxWidth + 7) / 8;

  // File layout constants.
  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned Planes      = 4;
  localparam int unsigned StoredPlanes = 3;
  localparam int unsigned PixPerByte  = 8;

  // Field widths.
  localparam int unsigned LenW  = 24;
  localparam int unsigned ColW  = 10;
  localparam int unsigned RowW  = 9;
  localparam int unsigned RbW   = $clog2(RowBytesMax + 1);
  localparam int unsigned AddrW = $clog2(RowBytesMax);
  localparam int unsigned NeedW =
    $clog2(HeaderBytes + Planes * RowBytesMax * MaxHeight + 1);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

endpackage

// ===== src/p2c_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module p2c_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/planar_icon_to_chunky_pixels.sv =====
// Output: the first result of a byte is shown in the cycle after the byte's beat.
// Flow: one byte per cycle while the output is not stalled, for bytes that give
// at most one result; an intensity byte holds the result stage until all its
// pixels (up to eight) leave the single result register one beat at a time.
// Reset: all control state clears asynchronously; the plane row store is not
// cleared, every entry is written for a row before that row reads it.
// Top level of the planar-to-chunky converter; uses p2c_pkg and p2c_ram.
module planar_icon_to_chunky_pixels
  import p2c_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration: data_length.
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  // Input bytes.
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]      s_axis_tuser,   // [0] first_byte
  // Results.
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // [3:0] pixel_index, [13:4] column, [22:14] row, [32:23] image_width,
  // [41:33] image_height, [47:42] zero
  output logic [47:0]     m_axis_tdata,
  output logic [2:0]      m_axis_tuser,   // [1:0] kind, [2] image_done
  output logic            m_axis_tlast    // last_of_run
);

  // Parser phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;

  // Parser state.
  logic [LenW-1:0] data_len_q;
  logic [1:0]      phase_q, phase_d;
  logic [2:0]      hpos_q, hpos_d;
  logic [15:0]     raw_w_q, raw_w_d;
  logic [7:0]      raw_h_lo_q, raw_h_lo_d;
  logic [ColW-1:0] width_q, width_d;
  logic [RowW-1:0] height_q, height_d;
  logic [1:0]      plane_q, plane_d;
  logic [RbW-1:0]  bip_q, bip_d;
  logic [RowW-1:0] row_q, row_d;

  // Result stage.
  logic            s1_valid_q;
  kind_e           s1_kind_q;
  logic [7:0]      s1_ibyte_q;
  logic [ColW-1:0] s1_base_q;
  logic [RowW-1:0] s1_row_q;
  logic [3:0]      s1_cnt_q;
  logic [ColW-1:0] s1_w_q;
  logic [RowW-1:0] s1_h_q;
  logic            s1_done_q;
  logic [2:0]      beat_q;

  // Item decode results.
  logic            in_fire, out_fire, last_beat;
  logic            item_res;
  kind_e           item_kind;
  logic [ColW-1:0] item_base;
  logic [3:0]      item_cnt;
  logic            item_done;
  logic            ram_we, ram_re;
  logic [7:0]      ram_q [StoredPlanes];

  // Current row length in bytes.
  logic [ColW:0]   rb_sum;
  logic [RbW-1:0]  rb_cur;
  assign rb_sum = {1'b0, width_q} + (ColW+1)'(7);
  assign rb_cur = rb_sum[3 +: RbW];

  // Header verdict inputs for header byte 3.
  logic [15:0]     raw_h;
  logic [ColW-1:0] w_new;
  logic [RowW-1:0] h_new;
  logic [ColW:0]   rb_new_sum;
  logic [RbW-1:0]  rb_new;
  logic [RbW+RowW-1:0] rb_h;
  logic [NeedW-1:0] need_len;
  assign raw_h      = {s_axis_tdata, raw_h_lo_q};
  assign w_new      = raw_w_q[ColW-1:0] + ColW'(1);
  assign h_new      = raw_h[RowW-1:0] + RowW'(1);
  assign rb_new_sum = {1'b0, w_new} + (ColW+1)'(7);
  assign rb_new     = rb_new_sum[3 +: RbW];
  assign rb_h       = {{RowW{1'b0}}, rb_new} * {{RbW{1'b0}}, h_new};
  assign need_len   = NeedW'(HeaderBytes) + NeedW'({rb_h, 2'b00});

  // Pixel byte geometry.
  logic [ColW-1:0] pix_base, pix_rem;
  logic [RowW:0]   row_inc;
  logic [RbW-1:0]  bip_inc;
  assign pix_base = ColW'({bip_q, 3'b000});
  assign pix_rem  = width_q - pix_base;
  assign row_inc  = {1'b0, row_q} + (RowW+1)'(1);
  assign bip_inc  = bip_q + RbW'(1);

  // Handshakes.
  assign last_beat     = ({1'b0, beat_q} + 4'd1) == s1_cnt_q;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !s1_valid_q || (m_axis_tready && last_beat);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Parser: one byte per beat, state advances at the beat.
  always_comb begin
    logic [1:0] eff_phase;
    logic [2:0] eff_pos;
    eff_phase  = s_axis_tuser[0] ? PH_HEADER : phase_q;
    eff_pos    = s_axis_tuser[0] ? 3'd0 : hpos_q;
    phase_d    = phase_q;
    hpos_d     = hpos_q;
    raw_w_d    = raw_w_q;
    raw_h_lo_d = raw_h_lo_q;
    width_d    = width_q;
    height_d   = height_q;
    plane_d    = plane_q;
    bip_d      = bip_q;
    row_d      = row_q;
    item_res   = 1'b0;
    item_kind  = KIND_REJECT;
    item_base  = pix_base;
    item_cnt   = 4'd1;
    item_done  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (in_fire) begin
      phase_d = eff_phase;
      case (eff_phase)
        PH_HEADER: begin
          hpos_d = eff_pos + 3'd1;
          case (eff_pos)
            3'd0: begin
              raw_w_d = {8'h00, s_axis_tdata};
              if (data_len_q < LenW'(HeaderBytes)) begin
                phase_d  = PH_IDLE;
                item_res = 1'b1;
              end
            end
            3'd1: raw_w_d = {s_axis_tdata, raw_w_q[7:0]};
            3'd2: raw_h_lo_d = s_axis_tdata;
            3'd3: begin
              item_res = 1'b1;
              // A raw size at or above the limit is either too large or
              // wraps to zero.
              if (raw_w_q >= 16'(MaxWidth) || raw_h >= 16'(MaxHeight) ||
                  data_len_q < LenW'(need_len)) begin
                phase_d = PH_IDLE;
              end else begin
                width_d   = w_new;
                height_d  = h_new;
                item_kind = KIND_HEADER;
              end
            end
            default: begin
              if (eff_pos >= 3'd5) begin
                phase_d = PH_PIXELS;
                plane_d = 2'd0;
                bip_d   = '0;
                row_d   = '0;
              end
            end
          endcase
        end
        PH_PIXELS: begin
          if (bip_q >= RbW'(RowBytesMax) || rb_cur == '0) begin
            phase_d = PH_IDLE;
          end else begin
            if (plane_q < 2'(StoredPlanes)) begin
              ram_we = 1'b1;
            end else begin
              // Intensity byte: read back the three stored plane bytes.
              ram_re    = 1'b1;
              item_res  = 1'b1;
              item_kind = KIND_PIXEL;
              item_cnt  = (pix_rem > ColW'(PixPerByte)) ? 4'(PixPerByte)
                                                        : pix_rem[3:0];
              item_done = (row_inc == {1'b0, height_q}) &&
                          (pix_rem <= ColW'(PixPerByte));
            end
            // Step through bytes, planes and rows.
            if (bip_inc >= rb_cur) begin
              bip_d   = '0;
              plane_d = plane_q + 2'd1;
              if (plane_q == 2'(Planes - 1)) begin
                row_d = row_inc[RowW-1:0];
                if (row_inc >= {1'b0, height_q}) begin
                  phase_d = PH_IDLE;
                end
              end
            end else begin
              bip_d = bip_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_len_q <= '0;
      phase_q    <= PH_IDLE;
      hpos_q     <= '0;
      raw_w_q    <= '0;
      raw_h_lo_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
      plane_q    <= '0;
      bip_q      <= '0;
      row_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        data_len_q <= cfg_wdata_i;
      end
      phase_q    <= phase_d;
      hpos_q     <= hpos_d;
      raw_w_q    <= raw_w_d;
      raw_h_lo_q <= raw_h_lo_d;
      width_q    <= width_d;
      height_q   <= height_d;
      plane_q    <= plane_d;
      bip_q      <= bip_d;
      row_q      <= row_d;
    end
  end

  // Plane row store: one RAM per stored plane.
  for (genvar g = 0; g < StoredPlanes; g++) begin : g_plane
    p2c_ram #(
      .Width(8),
      .Depth(RowBytesMax)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we && (plane_q == 2'(g))),
      .waddr_i(bip_q[AddrW-1:0]),
      .wdata_i(s_axis_tdata),
      .re_i   (ram_re),
      .raddr_i(bip_q[AddrW-1:0]),
      .rdata_o(ram_q[g])
    );
  end

  // Result stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      beat_q     <= '0;
    end else if (item_res) begin
      s1_valid_q <= 1'b1;
      beat_q     <= '0;
    end else if (out_fire) begin
      if (last_beat) begin
        s1_valid_q <= 1'b0;
        beat_q     <= '0;
      end else begin
        beat_q <= beat_q + 3'd1;
      end
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (item_res) begin
      s1_kind_q  <= item_kind;
      s1_ibyte_q <= s_axis_tdata;
      s1_base_q  <= item_base;
      s1_row_q   <= row_q;
      s1_cnt_q   <= item_cnt;
      s1_w_q     <= w_new;
      s1_h_q     <= h_new;
      s1_done_q  <= item_done;
    end
  end

  // Output beat: pixels leave msb first.
  logic            is_pix, is_hdr;
  logic [2:0]      bit_sel;
  logic [3:0]      pix_out;
  logic [ColW-1:0] col_out;
  logic [RowW-1:0] row_out;
  logic [ColW-1:0] w_out;
  logic [RowW-1:0] h_out;
  assign is_pix  = s1_kind_q == KIND_PIXEL;
  assign is_hdr  = s1_kind_q == KIND_HEADER;
  assign bit_sel = 3'(PixPerByte - 1) - beat_q;
  assign pix_out = is_pix ? {s1_ibyte_q[bit_sel], ram_q[2][bit_sel],
                             ram_q[1][bit_sel], ram_q[0][bit_sel]} : 4'd0;
  assign col_out = is_pix ? s1_base_q + ColW'(beat_q) : '0;
  assign row_out = is_pix ? s1_row_q : '0;
  assign w_out   = is_hdr ? s1_w_q : '0;
  assign h_out   = is_hdr ? s1_h_q : '0;

  assign m_axis_tvalid = s1_valid_q;
  assign m_axis_tdata  = {6'b000000, h_out, w_out, row_out, col_out, pix_out};
  assign m_axis_tuser  = {s1_done_q && last_beat, s1_kind_q};
  assign m_axis_tlast  = last_beat;

`ifndef SYNTHESIS
  // The beat counter stays inside the item's pixel count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ({1'b0, beat_q} < s1_cnt_q))
    else $error("beat counter beyond pixel count");

  // Header and reject results are single beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !is_pix |-> s1_cnt_q == 4'd1)
    else $error("non-pixel result with several beats");

  // While decoding pixels the byte and row counters stay in the image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PIXELS |-> (bip_q < rb_cur) && (row_q < height_q))
    else $error("pixel counters out of range");

  // A stalled result keeps its place in the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !m_axis_tready |=> s1_valid_q && $stable(beat_q))
    else $error("result stage moved while stalled");

  // The end of the image only comes on a final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast && is_pix)
    else $error("image end off a final pixel beat");
`endif

endmodule
